@@ hdl/assert_macros.svh @@
// Assertion macros shared by the tone bank RTL.
// Depends on signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define SSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ssb_pkg.sv @@
// Shared constants, codes and types of the stacked stepper tone bank.
// No dependencies; every other file but assert_macros.svh imports it.
package ssb_pkg;

  localparam int NUM_OUTPUTS       = 8;
  localparam int OUTPUTS_PER_GROUP = 2;
  localparam int PERIOD_BITS       = 16;
  localparam int GROUP_COUNT       = 4;
  localparam int VEL_STEP          = 127 / OUTPUTS_PER_GROUP;

  // Field widths of the request and result transactions.
  localparam int REQ_W    = 3;
  localparam int GRP_IN_W = 2;
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int CH_W     = 4;
  localparam int PIN_W    = 16;
  localparam int IDX_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int ACT_W    = 4;

  // Internal widths.
  localparam int K_W   = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int MEM_W = (OUTPUTS_PER_GROUP > 1) ? $clog2(OUTPUTS_PER_GROUP) : 1;
  localparam int GRP_W = $clog2(NUM_OUTPUTS) + 2;
  localparam int CNT_W = $clog2(NUM_OUTPUTS + 1);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BEND     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP     = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;  // latch the accepted request, clear sweep counters
    logic step;     // update output k and advance
    logic finish;   // update group table, load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;     // sweep sits on the last output
  } ctrl_sts_t;

endpackage

@@ hdl/ssb_in_if.sv @@
// Request channel of the tone bank: valid/ready handshake plus request fields.
// Depends on ssb_pkg for field widths.
interface ssb_in_if;
  import ssb_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [GRP_IN_W-1:0] group_index;
  logic [NOTE_W-1:0]   note_number;
  logic [VEL_W-1:0]    note_velocity;
  logic [CH_W-1:0]     midi_channel;
  logic [PIN_W-1:0]    base_period;
  logic [PIN_W-1:0]    bent_period;
  logic [IDX_W-1:0]    output_index;

  modport source (
    output valid, req_type, group_index, note_number, note_velocity,
           midi_channel, base_period, bent_period, output_index,
    input  ready
  );

  modport sink (
    input  valid, req_type, group_index, note_number, note_velocity,
           midi_channel, base_period, bent_period, output_index,
    output ready
  );
endinterface

@@ hdl/ssb_out_if.sv @@
// Result channel of the tone bank: valid/ready handshake plus result fields.
// Depends on ssb_pkg for field widths.
interface ssb_out_if;
  import ssb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] step_levels;
  logic [BYTE_W-1:0] enable_mask;
  logic [ACT_W-1:0]  active_count;
  logic              group_busy;
  logic [NOTE_W-1:0] group_held_note;

  modport source (
    output valid, step_levels, enable_mask, active_count, group_busy, group_held_note,
    input  ready
  );

  modport sink (
    input  valid, step_levels, enable_mask, active_count, group_busy, group_held_note,
    output ready
  );
endinterface

@@ hdl/stacked_stepper_tone_bank_core.sv @@
// Top level of the stacked stepper tone bank.
// Depends on ssb_pkg, ssb_in_if, ssb_out_if, ssb_ctrl and ssb_dp.

// A bank of NUM_OUTPUTS square-wave step outputs, grouped OUTPUTS_PER_GROUP to a
// group, driven by one request transaction at a time (tick, note on, note off,
// period bend, stop all); every request returns exactly one result transaction
// with the step levels, enable mask, enabled count and the addressed group's
// held note, all taken after the update. A request is first accepted, then the
// sweep visits the per-output period, counter and owner stores at a single
// address, one output at a time, and last the group table is updated and the
// result register loaded. The result register stands between the two sides,
// so the next request is accepted while an earlier result still waits to be
// taken; a stalled result holds only the final cycle of the following request.
module stacked_stepper_tone_bank_core (
  input logic   clk,
  input logic   rst_n,
  ssb_in_if.sink   in_if,
  ssb_out_if.source out_if
);
  import ssb_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequence accept, sweep and result load.
  ssb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the per-output and group state, drive the result fields.
  ssb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .req_type        (in_if.req_type),
    .group_index     (in_if.group_index),
    .note_number     (in_if.note_number),
    .note_velocity   (in_if.note_velocity),
    .midi_channel    (in_if.midi_channel),
    .base_period     (in_if.base_period),
    .bent_period     (in_if.bent_period),
    .output_index    (in_if.output_index),
    .step_levels     (out_if.step_levels),
    .enable_mask     (out_if.enable_mask),
    .active_count    (out_if.active_count),
    .group_busy      (out_if.group_busy),
    .group_held_note (out_if.group_held_note)
  );
endmodule

@@ hdl/ssb_ctrl.sv @@
// Controller of the tone bank: sequences accept, per-output sweep and result load.
// Depends on ssb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ssb_pkg::ctrl_sts_t sts,
  output ssb_pkg::ctrl_cmd_t cmd
);
  import ssb_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the result register is free or drains this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `SSB_ASSERT(a_load_free, cmd.finish |-> (!out_valid_r || out_ready), "result overwritten while pending")
  `SSB_ASSERT_NEXT(a_sweep_end, (state_r == ST_SWEEP) && sts.last, state_r == ST_FINISH, "sweep did not end")
endmodule

@@ hdl/ssb_dp.sv @@
// Datapath of the tone bank: per-output period stores, group table, result register.
// Depends on ssb_pkg and assert_macros.svh; driven by ssb_ctrl commands.
`include "assert_macros.svh"

module ssb_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssb_pkg::ctrl_cmd_t           cmd,
  output ssb_pkg::ctrl_sts_t           sts,
  input  logic [ssb_pkg::REQ_W-1:0]    req_type,
  input  logic [ssb_pkg::GRP_IN_W-1:0] group_index,
  input  logic [ssb_pkg::NOTE_W-1:0]   note_number,
  input  logic [ssb_pkg::VEL_W-1:0]    note_velocity,
  input  logic [ssb_pkg::CH_W-1:0]     midi_channel,
  input  logic [ssb_pkg::PIN_W-1:0]    base_period,
  input  logic [ssb_pkg::PIN_W-1:0]    bent_period,
  input  logic [ssb_pkg::IDX_W-1:0]    output_index,
  output logic [ssb_pkg::BYTE_W-1:0]   step_levels,
  output logic [ssb_pkg::BYTE_W-1:0]   enable_mask,
  output logic [ssb_pkg::ACT_W-1:0]    active_count,
  output logic                         group_busy,
  output logic [ssb_pkg::NOTE_W-1:0]   group_held_note
);
  import ssb_pkg::*;

  // Latched request.
  logic [REQ_W-1:0]       req_r;
  logic [GRP_IN_W-1:0]    grp_in_r;
  logic [NOTE_W-1:0]      note_r;
  logic [VEL_W-1:0]       vel_r;
  logic [CH_W-1:0]        ch_r;
  logic [PERIOD_BITS-1:0] base_in_r;
  logic [PERIOD_BITS-1:0] bent_in_r;
  logic [IDX_W-1:0]       idx_r;

  // Sweep counters.
  logic [K_W-1:0]   k_r;
  logic [MEM_W-1:0] mem_r;
  logic [GRP_W-1:0] grp_r;
  logic [CNT_W-1:0] acc_r;
  logic [CNT_W-1:0] cnt_r;

  // Per-output state.
  logic [PERIOD_BITS-1:0] base_r [NUM_OUTPUTS];
  logic [PERIOD_BITS-1:0] play_r [NUM_OUTPUTS];
  logic [PERIOD_BITS-1:0] tcnt_r [NUM_OUTPUTS];
  logic [CH_W-1:0]        own_ch_r [NUM_OUTPUTS];
  logic [NUM_OUTPUTS-1:0] own_vld_r;
  logic [NUM_OUTPUTS-1:0] pin_r;
  logic [NUM_OUTPUTS-1:0] en_r;

  // Group table.
  logic [GROUP_COUNT-1:0] g_act_r;
  logic [NOTE_W-1:0]      g_note_r [GROUP_COUNT];

  // Result register.
  logic [BYTE_W-1:0] lvl_out_r;
  logic [BYTE_W-1:0] en_out_r;
  logic [ACT_W-1:0]  act_out_r;
  logic              busy_out_r;
  logic [NOTE_W-1:0] held_out_r;

  logic [PERIOD_BITS-1:0] cur_base, cur_play, cur_tcnt;
  logic [PERIOD_BITS-1:0] base_n, play_n, tcnt_n;
  logic [CH_W-1:0]        cur_ch, ch_n;
  logic                   cur_vld, vld_n, lvl_n, en_n;
  logic                   in_grp, vel_ok, is_tgt, off_match;
  logic [BYTE_W-1:0]      thr;
  logic                   busy_n;
  logic [NOTE_W-1:0]      held_n;

  assign cur_base = base_r[k_r];
  assign cur_play = play_r[k_r];
  assign cur_tcnt = tcnt_r[k_r];
  assign cur_ch   = own_ch_r[k_r];
  assign cur_vld  = own_vld_r[k_r];

  assign in_grp    = (grp_r == GRP_W'(grp_in_r));
  assign thr       = BYTE_W'(VEL_STEP) * BYTE_W'(mem_r);
  assign vel_ok    = (BYTE_W'(vel_r) >= thr);
  assign is_tgt    = (6'(k_r) == 6'(idx_r));
  assign off_match = (g_note_r[grp_in_r] == note_r);

  assign sts.last = (k_r == K_W'(NUM_OUTPUTS - 1));

  // Next value of the output under the sweep.
  always_comb begin
    base_n = cur_base;
    play_n = cur_play;
    tcnt_n = cur_tcnt;
    ch_n   = cur_ch;
    vld_n  = cur_vld;
    lvl_n  = pin_r[k_r];
    en_n   = en_r[k_r];
    case (req_r)
      REQ_TICK: begin
        if (cur_play != '0) begin
          if (cur_tcnt >= cur_play) begin
            lvl_n  = ~pin_r[k_r];
            tcnt_n = '0;
          end else begin
            tcnt_n = cur_tcnt + 1'b1;
          end
        end
      end
      REQ_NOTE_ON: begin
        if (in_grp && vel_ok) begin
          en_n   = 1'b1;
          base_n = base_in_r;
          play_n = bent_in_r;
          vld_n  = 1'b1;
          ch_n   = ch_r;
        end
      end
      REQ_NOTE_OFF: begin
        if (in_grp && off_match) begin
          en_n   = 1'b0;
          lvl_n  = 1'b0;
          vld_n  = 1'b0;
          ch_n   = '0;
          base_n = '0;
          play_n = '0;
        end
      end
      REQ_BEND: begin
        if (is_tgt && (cur_base != '0) && cur_vld && (cur_ch == ch_r)) begin
          play_n = bent_in_r;
        end
      end
      REQ_STOP: begin
        en_n   = 1'b0;
        lvl_n  = 1'b0;
        vld_n  = 1'b0;
        ch_n   = '0;
        base_n = '0;
        play_n = '0;
        tcnt_n = '0;
      end
      default: begin
      end
    endcase
  end

  // Group entry after the request, as reported.
  always_comb begin
    busy_n = g_act_r[grp_in_r];
    held_n = g_note_r[grp_in_r];
    case (req_r)
      REQ_NOTE_ON: begin
        busy_n = 1'b1;
        held_n = note_r;
      end
      REQ_NOTE_OFF: begin
        if (off_match) begin
          busy_n = 1'b0;
        end
      end
      REQ_STOP: begin
        busy_n = 1'b0;
      end
      default: begin
      end
    endcase
    if (!busy_n) begin
      held_n = '0;
    end
  end

  // Request latch and result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= req_type;
      grp_in_r  <= group_index;
      note_r    <= note_number;
      vel_r     <= note_velocity;
      ch_r      <= midi_channel;
      base_in_r <= PERIOD_BITS'(base_period);
      bent_in_r <= PERIOD_BITS'(bent_period);
      idx_r     <= output_index;
    end
    if (cmd.finish) begin
      lvl_out_r  <= BYTE_W'(pin_r);
      en_out_r   <= BYTE_W'(en_r);
      act_out_r  <= ACT_W'(acc_r);
      busy_out_r <= busy_n;
      held_out_r <= held_n;
    end
  end

  // Sweep counters, per-output state and group table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      mem_r     <= '0;
      grp_r     <= '0;
      acc_r     <= '0;
      cnt_r     <= '0;
      own_vld_r <= '0;
      pin_r     <= '0;
      en_r      <= '0;
      g_act_r   <= '0;
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        base_r[i]   <= '0;
        play_r[i]   <= '0;
        tcnt_r[i]   <= '0;
        own_ch_r[i] <= '0;
      end
      for (int j = 0; j < GROUP_COUNT; j++) begin
        g_note_r[j] <= '0;
      end
    end else begin
      if (cmd.capture) begin
        k_r   <= '0;
        mem_r <= '0;
        grp_r <= '0;
        acc_r <= '0;
      end
      if (cmd.step) begin
        base_r[k_r]    <= base_n;
        play_r[k_r]    <= play_n;
        tcnt_r[k_r]    <= tcnt_n;
        own_ch_r[k_r]  <= ch_n;
        own_vld_r[k_r] <= vld_n;
        pin_r[k_r]     <= lvl_n;
        en_r[k_r]      <= en_n;
        acc_r          <= acc_r + CNT_W'(en_n);
        k_r            <= k_r + 1'b1;
        if (mem_r == MEM_W'(OUTPUTS_PER_GROUP - 1)) begin
          mem_r <= '0;
          grp_r <= grp_r + 1'b1;
        end else begin
          mem_r <= mem_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        cnt_r <= acc_r;
        case (req_r)
          REQ_NOTE_ON: begin
            g_act_r[grp_in_r]  <= 1'b1;
            g_note_r[grp_in_r] <= note_r;
          end
          REQ_NOTE_OFF: begin
            if (off_match) begin
              g_act_r[grp_in_r]  <= 1'b0;
              g_note_r[grp_in_r] <= '0;
            end
          end
          REQ_STOP: begin
            g_act_r <= '0;
            for (int j = 0; j < GROUP_COUNT; j++) begin
              g_note_r[j] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign step_levels     = lvl_out_r;
  assign enable_mask     = en_out_r;
  assign active_count    = act_out_r;
  assign group_busy      = busy_out_r;
  assign group_held_note = held_out_r;

  `SSB_ASSERT(a_count_match, cmd.capture |-> ($countones(en_r) == int'(cnt_r)), "enabled count drifted")
endmodule

@@ tb/tone_bank_checker.sv @@
// Checker for the stacked stepper tone bank: predicts every readout and compares.
// Depends on ssb_pkg, ssb_in_if and ssb_out_if; instantiated by the testbench top.
module tone_bank_checker (
  input  logic clk,
  input  logic rst_n,
  ssb_in_if    req_ch,
  ssb_out_if   res_ch,
  output int   mismatch_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssb_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] levels;
    logic [BYTE_W-1:0] enables;
    logic [ACT_W-1:0]  active;
    logic              busy;
    logic [NOTE_W-1:0] held;
  } bank_readout_t;

  // Shadow copy of the bank.
  logic [PIN_W-1:0]       stored_base [NUM_OUTPUTS];
  logic [PIN_W-1:0]       play_period [NUM_OUTPUTS];
  logic [PIN_W-1:0]       tick_count  [NUM_OUTPUTS];
  logic                   owner_valid [NUM_OUTPUTS];
  logic [CH_W-1:0]        owner_ch    [NUM_OUTPUTS];
  logic [NUM_OUTPUTS-1:0] pin_levels;
  logic [NUM_OUTPUTS-1:0] enables;
  logic                   group_active [GROUP_COUNT];
  logic [NOTE_W-1:0]      group_note   [GROUP_COUNT];

  bank_readout_t expected_readouts [$];
  int            readout_index;

  task automatic clear_bank();
    for (int k = 0; k < NUM_OUTPUTS; k++) begin
      stored_base[k] = '0;
      play_period[k] = '0;
      tick_count[k]  = '0;
      owner_valid[k] = 1'b0;
      owner_ch[k]    = '0;
    end
    for (int g = 0; g < GROUP_COUNT; g++) begin
      group_active[g] = 1'b0;
      group_note[g]   = '0;
    end
    pin_levels = '0;
    enables    = '0;
  endtask

  // Advance the shadow bank by one request and return the readout after it.
  task automatic advance_bank(output bank_readout_t rd);
    int k;
    int g;
    g = req_ch.group_index;
    case (req_ch.req_type)
      REQ_TICK: begin
        for (k = 0; k < NUM_OUTPUTS; k++) begin
          if (play_period[k] != '0) begin
            if (tick_count[k] >= play_period[k]) begin
              pin_levels[k] = ~pin_levels[k];
              tick_count[k] = '0;
            end else begin
              tick_count[k] = tick_count[k] + 1'b1;
            end
          end
        end
      end
      REQ_NOTE_ON: begin
        group_active[g] = 1'b1;
        group_note[g]   = req_ch.note_number;
        for (int i = 0; i < OUTPUTS_PER_GROUP; i++) begin
          k = g * OUTPUTS_PER_GROUP + i;
          if (int'(req_ch.note_velocity) < VEL_STEP * i || k >= NUM_OUTPUTS) break;
          enables[k]     = 1'b1;
          stored_base[k] = req_ch.base_period;
          play_period[k] = req_ch.bent_period;
          owner_valid[k] = 1'b1;
          owner_ch[k]    = req_ch.midi_channel;
        end
      end
      REQ_NOTE_OFF: begin
        // the active flag plays no part in the match, so an idle group matches note 0
        if (group_note[g] == req_ch.note_number) begin
          group_active[g] = 1'b0;
          group_note[g]   = '0;
          for (int i = 0; i < OUTPUTS_PER_GROUP; i++) begin
            k = g * OUTPUTS_PER_GROUP + i;
            if (k >= NUM_OUTPUTS) break;
            enables[k]     = 1'b0;
            pin_levels[k]  = 1'b0;
            owner_valid[k] = 1'b0;
            owner_ch[k]    = '0;
            stored_base[k] = '0;
            play_period[k] = '0;
          end
        end
      end
      REQ_BEND: begin
        k = req_ch.output_index;
        if (k < NUM_OUTPUTS && stored_base[k] != '0 && owner_valid[k] &&
            owner_ch[k] == req_ch.midi_channel)
          play_period[k] = req_ch.bent_period;
      end
      REQ_STOP: clear_bank();
      default: ;
    endcase
    rd.levels  = pin_levels[BYTE_W-1:0];
    rd.enables = enables[BYTE_W-1:0];
    rd.active  = ACT_W'($countones(enables));
    rd.busy    = group_active[g];
    rd.held    = group_active[g] ? group_note[g] : '0;
  endtask

  task automatic report(input string field, input int got, input int want);
    mismatch_count++;
    $display("[%0t] readout %0d: %s got 0x%0h, want 0x%0h",
             $time, readout_index, field, got, want);
  endtask

  always @(posedge clk) begin
    bank_readout_t rd;
    if (!rst_n) begin
      clear_bank();
      expected_readouts.delete();
    end else begin
      // Retire before predicting: a new request cannot produce a result this edge.
      if (res_ch.valid && res_ch.ready) begin
        if (expected_readouts.size() == 0) begin
          report("readout with nothing pending", 1, 0);
        end else begin
          rd = expected_readouts.pop_front();
          if (res_ch.step_levels !== rd.levels)
            report("step_levels", res_ch.step_levels, rd.levels);
          if (res_ch.enable_mask !== rd.enables)
            report("enable_mask", res_ch.enable_mask, rd.enables);
          if (res_ch.active_count !== rd.active)
            report("active_count", res_ch.active_count, rd.active);
          if (res_ch.group_busy !== rd.busy)
            report("group_busy", res_ch.group_busy, rd.busy);
          if (res_ch.group_held_note !== rd.held)
            report("group_held_note", res_ch.group_held_note, rd.held);
        end
        readout_index++;
      end
      if (req_ch.valid && req_ch.ready) begin
        advance_bank(rd);
        expected_readouts.push_back(rd);
      end
    end
    outstanding <= expected_readouts.size();
  end

endmodule

@@ tb/tb_stacked_stepper_tone_bank_core.sv @@
// Testbench top for stacked_stepper_tone_bank_core: clock, reset, stimulus, verdict.
// Depends on ssb_pkg, both channel interfaces, the RTL and tone_bank_checker.
module tb_stacked_stepper_tone_bank_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ssb_pkg::*;

  // Request codes the block must ignore.
  localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 3'd5;
  localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = 3'd7;

  localparam int RANDOM_ITEMS  = 1400;
  // Wait after the last readout before the verdict.
  localparam int SETTLE_CYCLES = 40;
  // Watchdog bound for a run of roughly 1425 items, with a wide margin.
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_MOSTLY,
    RDY_SPARSE
  } stall_mode_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [GRP_IN_W-1:0] grp;
    logic [NOTE_W-1:0]   note;
    logic [VEL_W-1:0]    vel;
    logic [CH_W-1:0]     ch;
    logic [PIN_W-1:0]    base;
    logic [PIN_W-1:0]    bent;
    logic [IDX_W-1:0]    idx;
  } bank_req_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ssb_in_if  req_ch ();
  ssb_out_if res_ch ();

  int mismatch_count;
  int outstanding;
  int cycle_count;
  int burst_left;

  // Stimulus hints: the note each group is believed to hold and the channel of
  // each output, so that most note offs and bends hit something.
  logic [NOTE_W-1:0] held_hint [GROUP_COUNT];
  logic [CH_W-1:0]   chan_hint [NUM_OUTPUTS];

  stall_mode_t ready_mode  = RDY_ALWAYS;
  int          ready_phase = 0;

  stacked_stepper_tone_bank_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (res_ch)
  );

  tone_bank_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_ch         (req_ch),
    .res_ch         (res_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: end the run if the bank stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: switch to a random stall mode whenever the phase count runs out, so
  // that some stretches take every readout at once and others hold readouts back.
  always @(posedge clk) begin
    if (ready_phase == 0) begin
      ready_mode  <= stall_mode_t'($urandom_range(0, 3));
      ready_phase <= $urandom_range(20, 80);
    end else begin
      ready_phase <= ready_phase - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: res_ch.ready <= 1'b1;
      RDY_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
      RDY_MOSTLY: res_ch.ready <= ($urandom_range(0, 5) != 0);
      default:    res_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic bank_req_t make_req(
    input logic [REQ_W-1:0] req, input int grp, input int note, input int vel,
    input int ch, input int base, input int bent, input int idx);
    bank_req_t r;
    r.req  = req;
    r.grp  = GRP_IN_W'(grp);
    r.note = NOTE_W'(note);
    r.vel  = VEL_W'(vel);
    r.ch   = CH_W'(ch);
    r.base = PIN_W'(base);
    r.bent = PIN_W'(bent);
    r.idx  = IDX_W'(idx);
    return r;
  endfunction

  // Mostly short periods so that ticks toggle the pins often; now and then
  // zero, the maximum or anything at all.
  function automatic logic [PIN_W-1:0] pick_period();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return PIN_W'($urandom_range(1, 6));
    if (pick == 7) return '0;
    if (pick == 8) return '1;
    return PIN_W'($urandom);
  endfunction

  function automatic bank_req_t random_request();
    bank_req_t r;
    int pick;
    int k;
    r.req  = REQ_TICK;
    r.grp  = GRP_IN_W'($urandom_range(0, GROUP_COUNT - 1));
    r.note = NOTE_W'($urandom);
    r.vel  = VEL_W'($urandom);
    r.ch   = CH_W'($urandom);
    r.base = PIN_W'($urandom);
    r.bent = PIN_W'($urandom);
    r.idx  = IDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 44) begin
      r.req = REQ_TICK;
    end else if (pick < 64) begin
      r.req  = REQ_NOTE_ON;
      r.base = pick_period();
      r.bent = pick_period();
      held_hint[r.grp] = r.note;
      for (int i = 0; i < OUTPUTS_PER_GROUP; i++) begin
        k = r.grp * OUTPUTS_PER_GROUP + i;
        if (k < NUM_OUTPUTS) chan_hint[k] = r.ch;
      end
    end else if (pick < 78) begin
      r.req = REQ_NOTE_OFF;
      if ($urandom_range(0, 9) < 7) r.note = held_hint[r.grp];
      if (r.note == held_hint[r.grp]) held_hint[r.grp] = '0;
    end else if (pick < 92) begin
      r.req  = REQ_BEND;
      r.bent = pick_period();
      if ($urandom_range(0, 9) < 7) r.ch = chan_hint[r.idx];
    end else if (pick < 95) begin
      r.req = REQ_STOP;
      for (int g = 0; g < GROUP_COUNT; g++) held_hint[g] = '0;
    end else if (pick < 97) begin
      r.req = REQ_W'($urandom_range(int'(REQ_FIRST_UNUSED), int'(REQ_LAST_UNUSED)));
    end else begin
      // noise: any code with any content
      r.req = REQ_W'($urandom);
    end
    return r;
  endfunction

  // Present one request and hold it until the bank takes it. Requests come in
  // bursts; between bursts, drop valid for a random gap.
  task automatic send_request(input bank_req_t r);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= r.req;
    req_ch.group_index   <= r.grp;
    req_ch.note_number   <= r.note;
    req_ch.note_velocity <= r.vel;
    req_ch.midi_channel  <= r.ch;
    req_ch.base_period   <= r.base;
    req_ch.bent_period   <= r.bent;
    req_ch.output_index  <= r.idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Hold off the sender until every predicted readout has been taken. The
  // first edge lets the checker's count catch up with the last transaction.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_request(make_req(REQ_TICK,     0,   0,   0,  0,     0,     0, 0));
    // full velocity fills group 0; short period to see toggles
    send_request(make_req(REQ_NOTE_ON,  0,  60, 127,  0,     3,     3, 0));
    // zero velocity reaches only the first output of group 1
    send_request(make_req(REQ_NOTE_ON,  1, 127,   0, 15, 65535,     1, 0));
    // velocity just below one step; zero base period blocks later bends
    send_request(make_req(REQ_NOTE_ON,  2,   0,  62,  5,     0,     2, 0));
    // velocity exactly one step; zero play period keeps the pins still
    send_request(make_req(REQ_NOTE_ON,  3,  33,  63,  9,     5,     0, 0));
    repeat (4) send_request(make_req(REQ_TICK, 1, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_BEND,     0,   0,   0,  0,     0,     1, 0));
    // channel mismatch, base zero and a valid bend to the maximum period
    send_request(make_req(REQ_BEND,     0,   0,   0,  3,     0,     7, 2));
    send_request(make_req(REQ_BEND,     2,   0,   0,  5,     0,     9, 4));
    send_request(make_req(REQ_BEND,     3,   0,   0,  9,     0, 65535, 7));
    repeat (3) send_request(make_req(REQ_TICK, 3, 0, 0, 0, 0, 0, 0));
    // note off with the wrong note, then the right one
    send_request(make_req(REQ_NOTE_OFF, 0,  61,   0,  0,     0,     0, 0));
    send_request(make_req(REQ_NOTE_OFF, 0,  60,   0,  0,     0,     0, 0));
    // an idle group holds note 0, so this clears it again
    send_request(make_req(REQ_NOTE_OFF, 0,   0,   0,  0,     0,     0, 0));
    // repeated note on keeps counters and levels
    send_request(make_req(REQ_NOTE_ON,  1,  10, 127,  2,     4,     2, 0));
    send_request(make_req(REQ_TICK,     1,   0,   0,  0,     0,     0, 0));
    send_request(make_req(REQ_FIRST_UNUSED,     2, 127, 127, 15, 65535, 65535, 7));
    send_request(make_req(REQ_W'(REQ_FIRST_UNUSED + 1), 1, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_LAST_UNUSED,      3,   5,   5,  5,     5,     5, 5));
    send_request(make_req(REQ_STOP,     3,   0,   0,  0,     0,     0, 0));
    // owner invalid after stop all
    send_request(make_req(REQ_BEND,     3,   0,   0,  9,     0,     3, 6));
    send_request(make_req(REQ_TICK,     2,   0,   0,  0,     0,     0, 0));
  endtask

  initial begin
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_TICK;
    req_ch.group_index   <= '0;
    req_ch.note_number   <= '0;
    req_ch.note_velocity <= '0;
    req_ch.midi_channel  <= '0;
    req_ch.base_period   <= '0;
    req_ch.bent_period   <= '0;
    req_ch.output_index  <= '0;
    burst_left = 0;
    for (int g = 0; g < GROUP_COUNT; g++) held_hint[g] = '0;
    for (int k = 0; k < NUM_OUTPUTS; k++) chan_hint[k] = '0;

    // Hold reset at the start, then release it once for the whole run.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // pause now and then until the bank has answered everything
      if (n % 350 == 175) drain();
      send_request(random_request());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
